[rtl/core/mfs_pkg.sv]
package mfs_pkg;

  // Request kind carried on the input tuser
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // Result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_PUSH_DONE = 2'd0,
    ST_POP_DONE  = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_PUSH_FULL = 2'd3
  } status_e;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'b001,
    SEQ_READ  = 3'b010,
    SEQ_WRITE = 3'b100
  } seq_e;

  // Free list commands
  typedef struct packed {
    logic alloc;
    logic release_slot;
  } fl_ctl_t;

  // Entry store write enables
  typedef struct packed {
    logic lt_we;
    logic ent_we;
  } es_wr_t;

endpackage

[rtl/core/mfs_freq_mem.sv]
module mfs_freq_mem #(
  parameter int unsigned VALUE_BITS = 10,
  parameter int unsigned CNT_W      = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [VALUE_BITS-1:0] rd_addr_i,
  output logic [CNT_W-1:0]      rd_data_o,
  input  logic                  wr_en_i,
  input  logic [VALUE_BITS-1:0] wr_addr_i,
  input  logic [CNT_W-1:0]      wr_data_i,
  output logic                  ready_o
);

  localparam int unsigned Span = 1 << VALUE_BITS;

  logic [CNT_W-1:0]      mem [Span];
  logic [CNT_W-1:0]      rd_data_q;
  logic                  clr_busy_q, clr_busy_d;
  logic [VALUE_BITS-1:0] clr_addr_q, clr_addr_d;

  // clearing sweep after reset, one entry per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + VALUE_BITS'(1);
      if (clr_addr_q == {VALUE_BITS{1'b1}}) clr_busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_addr_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ~clr_busy_q;

endmodule

[rtl/core/mfs_entry_store.sv]
module mfs_entry_store #(
  parameter int unsigned VALUE_BITS = 10,
  parameter int unsigned SLOT_W     = 6,
  parameter int unsigned CAPACITY   = 64
) (
  input  logic                  clk_i,
  input  mfs_pkg::es_wr_t       wr_i,
  // level top memory
  input  logic [SLOT_W-1:0]     lt_rd_addr_i,
  output logic [SLOT_W-1:0]     lt_rd_data_o,
  input  logic [SLOT_W-1:0]     lt_wr_addr_i,
  input  logic [SLOT_W-1:0]     lt_wr_data_i,
  // entry memory
  input  logic [SLOT_W-1:0]     ent_rd_addr_i,
  output logic [VALUE_BITS-1:0] ent_val_o,
  output logic [SLOT_W-1:0]     ent_below_o,
  output logic                  ent_bottom_o,
  input  logic [SLOT_W-1:0]     ent_wr_addr_i,
  input  logic [VALUE_BITS-1:0] ent_wr_val_i,
  input  logic [SLOT_W-1:0]     ent_wr_below_i,
  input  logic                  ent_wr_bottom_i
);

  import mfs_pkg::*;

  logic [SLOT_W-1:0]     lt_mem     [CAPACITY];
  logic [VALUE_BITS-1:0] val_mem    [CAPACITY];
  logic [SLOT_W-1:0]     below_mem  [CAPACITY];
  logic                  bottom_mem [CAPACITY];

  logic [SLOT_W-1:0]     lt_rd_q;
  logic [VALUE_BITS-1:0] val_rd_q;
  logic [SLOT_W-1:0]     below_rd_q;
  logic                  bottom_rd_q;

  // newest slot of each level
  always_ff @(posedge clk_i) begin
    if (wr_i.lt_we) lt_mem[lt_wr_addr_i] <= lt_wr_data_i;
    lt_rd_q <= lt_mem[lt_rd_addr_i];
  end

  // linked entries; bottom marks the oldest entry of its level
  always_ff @(posedge clk_i) begin
    if (wr_i.ent_we) begin
      val_mem[ent_wr_addr_i]    <= ent_wr_val_i;
      below_mem[ent_wr_addr_i]  <= ent_wr_below_i;
      bottom_mem[ent_wr_addr_i] <= ent_wr_bottom_i;
    end
    val_rd_q    <= val_mem[ent_rd_addr_i];
    below_rd_q  <= below_mem[ent_rd_addr_i];
    bottom_rd_q <= bottom_mem[ent_rd_addr_i];
  end

  assign lt_rd_data_o = lt_rd_q;
  assign ent_val_o    = val_rd_q;
  assign ent_below_o  = below_rd_q;
  assign ent_bottom_o = bottom_rd_q;

endmodule

[rtl/core/mfs_free_list.sv]
module mfs_free_list #(
  parameter int unsigned SLOT_W   = 6,
  parameter int unsigned CNT_W    = 7,
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mfs_pkg::fl_ctl_t  ctl_i,
  input  logic [SLOT_W-1:0] rel_slot_i,
  output logic [SLOT_W-1:0] slot_o,
  output logic              full_o
);

  import mfs_pkg::*;

  // stack of returned slots, plus a counter of never-used slots
  logic [SLOT_W-1:0] stack_mem [CAPACITY];
  logic [SLOT_W-1:0] rd_q;
  logic [CNT_W-1:0]  depth_q, depth_d;
  logic [CNT_W-1:0]  fresh_q, fresh_d;
  logic              has_stack;

  assign has_stack = (depth_q != '0);
  assign slot_o    = has_stack ? rd_q : fresh_q[SLOT_W-1:0];
  assign full_o    = ~has_stack && (fresh_q == CNT_W'(CAPACITY));

  // counter update
  always_comb begin
    depth_d = depth_q;
    fresh_d = fresh_q;
    if (ctl_i.alloc) begin
      if (has_stack) depth_d = depth_q - CNT_W'(1);
      else           fresh_d = fresh_q + CNT_W'(1);
    end else if (ctl_i.release_slot) begin
      depth_d = depth_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      fresh_q <= '0;
    end else begin
      depth_q <= depth_d;
      fresh_q <= fresh_d;
    end
  end

  // stack memory: top is read every cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.release_slot) stack_mem[depth_q[SLOT_W-1:0]] <= rel_slot_i;
    rd_q <= stack_mem[SLOT_W'(depth_q - CNT_W'(1))];
  end

endmodule

[rtl/core/max_frequency_stack.sv]
// Maximum frequency stack. Each input word is a push (tuser 0, value in tdata)
// or a pop (tuser 1). A pop returns the value with the highest count, the
// newest among equals; status on the output tuser tells push done, pop done,
// pop on empty or push refused because all CAPACITY entries are in use.
// Every word yields exactly one output word. A word passes through the
// steps accept, read and write back in turn: a push reads the value's count
// and then the top of that count's level, a pop reads the top of the highest
// level and then that entry; the second read is addressed by the first.
// A new word is taken once the previous one is written back and the output
// register is free or being emptied. After reset the count memory is cleared
// one entry per cycle over all 2**VALUE_BITS entries (1024 by default), and
// tready stays low until that is done.
module max_frequency_stack #(
  parameter int unsigned VALUE_BITS = 10,
  parameter int unsigned CAPACITY   = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // [VALUE_BITS-1:0] value
  input  logic [0:0]                          s_axis_tuser,  // [0] opcode
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [((VALUE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // [VALUE_BITS-1:0] popped_value
  output logic [1:0]                          m_axis_tuser   // [1:0] status
);

  import mfs_pkg::*;

  localparam int unsigned DataW = ((VALUE_BITS + 7) / 8) * 8;
  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);

  seq_e                  state_q, state_d;
  op_e                   op_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CntW-1:0]       cnt_q;
  logic [SlotW-1:0]      slot_q;
  logic [CntW-1:0]       hi_q, hi_d;
  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] out_val_q;
  status_e               out_st_q;

  logic                  accept;
  logic                  clr_done;
  logic [CntW-1:0]       freq_rd;
  logic                  freq_we;
  logic [VALUE_BITS-1:0] freq_wa;
  logic [CntW-1:0]       freq_wd;
  logic [SlotW-1:0]      hi_m1;
  logic [SlotW-1:0]      lt_ra, lt_rd, lt_wa, lt_wd;
  logic [VALUE_BITS-1:0] ent_val;
  logic [SlotW-1:0]      ent_below;
  logic                  ent_bottom;
  es_wr_t                es_wr;
  fl_ctl_t               fl_ctl;
  logic [SlotW-1:0]      fl_slot;
  logic                  fl_full;
  logic                  push_ok, pop_ok, push_bottom;
  logic                  in_write;

  assign accept        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == SEQ_IDLE) & clr_done &
                         (~out_valid_q | m_axis_tready);
  assign in_write      = (state_q == SEQ_WRITE);
  assign hi_m1         = SlotW'(hi_q - CntW'(1));
  assign push_ok       = in_write & (op_q == OP_PUSH) & ~fl_full;
  assign pop_ok        = in_write & (op_q == OP_POP) & (hi_q != '0);
  assign push_bottom   = (cnt_q == hi_q);

  // level top read: highest level at accept, pushed level in read cycle
  assign lt_ra = (state_q == SEQ_READ) ? freq_rd[SlotW-1:0] : hi_m1;

  // write-back cycle controls
  always_comb begin
    freq_we             = push_ok | pop_ok;
    freq_wa             = pop_ok ? ent_val : val_q;
    freq_wd             = pop_ok ? (hi_q - CntW'(1)) : (cnt_q + CntW'(1));
    es_wr.lt_we         = push_ok | (pop_ok & ~ent_bottom);
    es_wr.ent_we        = push_ok;
    lt_wa               = pop_ok ? hi_m1 : cnt_q[SlotW-1:0];
    lt_wd               = pop_ok ? ent_below : fl_slot;
    fl_ctl.alloc        = push_ok;
    fl_ctl.release_slot = pop_ok;
    hi_d                = hi_q;
    if (push_ok && push_bottom) hi_d = cnt_q + CntW'(1);
    if (pop_ok && ent_bottom)   hi_d = hi_q - CntW'(1);
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE:  if (accept) state_d = SEQ_READ;
      SEQ_READ:  state_d = SEQ_WRITE;
      SEQ_WRITE: state_d = SEQ_IDLE;
      default:   state_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      hi_q    <= hi_d;
      if (in_write)                         out_valid_q <= 1'b1;
      else if (m_axis_tready & out_valid_q) out_valid_q <= 1'b0;
    end
  end

  // request and intermediate payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(s_axis_tuser[0]);
      val_q <= s_axis_tdata[VALUE_BITS-1:0];
    end
    if (state_q == SEQ_READ) begin
      cnt_q  <= freq_rd;
      slot_q <= lt_rd;
    end
    if (in_write) begin
      if (op_q == OP_PUSH) begin
        out_val_q <= '0;
        out_st_q  <= fl_full ? ST_PUSH_FULL : ST_PUSH_DONE;
      end else if (hi_q != '0) begin
        out_val_q <= ent_val;
        out_st_q  <= ST_POP_DONE;
      end else begin
        out_val_q <= '0;
        out_st_q  <= ST_POP_EMPTY;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DataW'(out_val_q);
  assign m_axis_tuser  = out_st_q;

  mfs_freq_mem #(
    .VALUE_BITS (VALUE_BITS),
    .CNT_W      (CntW)
  ) u_freq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (s_axis_tdata[VALUE_BITS-1:0]),
    .rd_data_o (freq_rd),
    .wr_en_i   (freq_we),
    .wr_addr_i (freq_wa),
    .wr_data_i (freq_wd),
    .ready_o   (clr_done)
  );

  mfs_entry_store #(
    .VALUE_BITS (VALUE_BITS),
    .SLOT_W     (SlotW),
    .CAPACITY   (CAPACITY)
  ) u_store (
    .clk_i           (clk_i),
    .wr_i            (es_wr),
    .lt_rd_addr_i    (lt_ra),
    .lt_rd_data_o    (lt_rd),
    .lt_wr_addr_i    (lt_wa),
    .lt_wr_data_i    (lt_wd),
    .ent_rd_addr_i   (lt_rd),
    .ent_val_o       (ent_val),
    .ent_below_o     (ent_below),
    .ent_bottom_o    (ent_bottom),
    .ent_wr_addr_i   (fl_slot),
    .ent_wr_val_i    (val_q),
    .ent_wr_below_i  (lt_rd),
    .ent_wr_bottom_i (push_bottom)
  );

  mfs_free_list #(
    .SLOT_W   (SlotW),
    .CNT_W    (CntW),
    .CAPACITY (CAPACITY)
  ) u_free (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (fl_ctl),
    .rel_slot_i (slot_q),
    .slot_o     (fl_slot),
    .full_o     (fl_full)
  );

endmodule
